### rtl/uft_pkg.sv
package uft_pkg;

  localparam int unsigned MaxNodesDef = 1024;
  localparam int unsigned NodeW       = 11;
  localparam int unsigned EdgeW       = 16;
  localparam int unsigned RankW       = 4;
  localparam int unsigned CntW        = 17;
  localparam logic [RankW-1:0] RankMax = '1;
  localparam logic [EdgeW-1:0] EdgeMax = '1;
  localparam logic [NodeW-1:0] NodeCountRst = 11'd1024;

  typedef enum logic [0:0] {
    MODE_CLEAR = 1'b0,
    MODE_EDGE  = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_F1_RD,
    S_F1_CHK,
    S_F2_RD,
    S_F2_WR,
    S_RK_A,
    S_RK_B,
    S_RK_C
  } state_e;

endpackage

### rtl/uft_ram.sv
module uft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/union_find_tree_check.sv
// Disjoint-set engine that tells whether an edge list forms a tree. A request
// with mode 0 starts a new graph: the counts are reset at once and its result
// strobes in the next cycle, after which the block sweeps both tables, one
// entry per cycle, and busy_o stays high until the last entry is written. The
// same sweep runs after reset, so the block takes no request after rst_ni
// rises until the sweep ends. An edge request with a bad endpoint strobes its
// result in the next cycle. A valid edge walks both parent chains in the
// parent memory. For each endpoint the find reads, then compares, each node
// up to the root, and the path compression pass then points every node on
// the path at that root; the rank lookups (S_RK_A, S_RK_B, S_RK_C) follow
// when the roots differ. The result of a valid edge strobes in the same cycle
// as busy_o falls.
// Every result is shown for exactly one cycle while done_o is high and
// cannot be held off, so the receiver must take it in that cycle.
module union_find_tree_check #(
  parameter int unsigned MAX_NODES = uft_pkg::MaxNodesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       mode_i,
  input  logic [uft_pkg::NodeW-1:0]  node_a_i,
  input  logic [uft_pkg::NodeW-1:0]  node_b_i,
  input  logic                       cfg_we_i,
  input  logic [uft_pkg::NodeW-1:0]  cfg_wdata_i,
  output logic                       done_o,
  output logic                       merged_o,
  output logic                       node_error_o,
  output logic [uft_pkg::NodeW-1:0]  components_o,
  output logic [uft_pkg::EdgeW-1:0]  edges_seen_o,
  output logic                       is_tree_o
);

  import uft_pkg::*;

  localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(MAX_NODES - 1);
  localparam int unsigned CompRstInt = (MAX_NODES < 1024) ? MAX_NODES : 1024;
  localparam logic [NodeW-1:0] CompRst = NodeW'(CompRstInt);

  state_e state_q, state_d;
  logic [NodeW-1:0] node_count_q;
  logic [NodeW-1:0] comp_q, comp_d;
  logic [EdgeW-1:0] edge_q, edge_d;
  logic [IW-1:0] cur_q, cur_d, start_q, start_d, bidx_q, bidx_d;
  logic [IW-1:0] root_q, root_d, ra_q, ra_d;
  logic phase_q, phase_d;
  logic [RankW-1:0] rka_q, rka_d;
  logic done_q, done_d, merged_q, merged_d, err_q, err_d;

  logic [CntW-1:0] n_eff;
  logic bad;
  logic [NodeW-1:0] am1, bm1;

  logic p_we, r_we;
  logic [IW-1:0] p_waddr, p_raddr, r_waddr, r_raddr;
  logic [IW-1:0] p_wdata, p_rdata;
  logic [RankW-1:0] r_wdata, r_rdata;

  uft_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_parent (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  uft_ram #(.WIDTH(RankW), .DEPTH(MAX_NODES)) u_rank (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  // Effective node count: zero acts as one, and the count is capped at the
  // table depth.
  always_comb begin
    n_eff = CntW'(node_count_q);
    if (n_eff == '0) begin
      n_eff = CntW'(1);
    end
    if (n_eff > CntW'(MAX_NODES)) begin
      n_eff = CntW'(MAX_NODES);
    end
  end

  assign bad = (node_a_i == '0) || (node_b_i == '0) ||
               (CntW'(node_a_i) > n_eff) || (CntW'(node_b_i) > n_eff);
  assign am1 = node_a_i - NodeW'(1);
  assign bm1 = node_b_i - NodeW'(1);

  always_comb begin
    state_d  = state_q;
    comp_d   = comp_q;
    edge_d   = edge_q;
    cur_d    = cur_q;
    start_d  = start_q;
    bidx_d   = bidx_q;
    root_d   = root_q;
    ra_d     = ra_q;
    phase_d  = phase_q;
    rka_d    = rka_q;
    done_d   = 1'b0;
    merged_d = merged_q;
    err_d    = err_q;
    p_we     = 1'b0;
    p_waddr  = cur_q;
    p_wdata  = root_q;
    p_raddr  = cur_q;
    r_we     = 1'b0;
    r_waddr  = cur_q;
    r_wdata  = '0;
    r_raddr  = ra_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (mode_i == MODE_CLEAR) begin
            comp_d   = n_eff[NodeW-1:0];
            edge_d   = '0;
            done_d   = 1'b1;
            merged_d = 1'b0;
            err_d    = 1'b0;
            cur_d    = '0;
            state_d  = S_CLEAR;
          end else if (bad) begin
            done_d   = 1'b1;
            merged_d = 1'b0;
            err_d    = 1'b1;
          end else begin
            cur_d   = IW'(am1);
            start_d = IW'(am1);
            bidx_d  = IW'(bm1);
            phase_d = 1'b0;
            state_d = S_F1_RD;
          end
        end
      end
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = cur_q;
        p_wdata = cur_q;
        r_we    = 1'b1;
        r_waddr = cur_q;
        r_wdata = '0;
        cur_d   = cur_q + IW'(1);
        if (cur_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_F1_RD: begin
        p_raddr = cur_q;
        state_d = S_F1_CHK;
      end
      S_F1_CHK: begin
        if (p_rdata == cur_q) begin
          root_d  = cur_q;
          cur_d   = start_q;
          state_d = S_F2_RD;
        end else begin
          cur_d   = p_rdata;
          state_d = S_F1_RD;
        end
      end
      S_F2_RD: begin
        if (cur_q == root_q) begin
          if (!phase_q) begin
            ra_d    = root_q;
            phase_d = 1'b1;
            cur_d   = bidx_q;
            start_d = bidx_q;
            state_d = S_F1_RD;
          end else begin
            if (edge_q != EdgeMax) begin
              edge_d = edge_q + EdgeW'(1);
            end
            if (ra_q == root_q) begin
              done_d   = 1'b1;
              merged_d = 1'b0;
              err_d    = 1'b0;
              state_d  = S_IDLE;
            end else begin
              state_d = S_RK_A;
            end
          end
        end else begin
          p_raddr = cur_q;
          state_d = S_F2_WR;
        end
      end
      S_F2_WR: begin
        // Point the node on the path straight at the root found above.
        p_we    = 1'b1;
        p_waddr = cur_q;
        p_wdata = root_q;
        cur_d   = p_rdata;
        state_d = S_F2_RD;
      end
      S_RK_A: begin
        r_raddr = ra_q;
        state_d = S_RK_B;
      end
      S_RK_B: begin
        r_raddr = root_q;
        rka_d   = r_rdata;
        state_d = S_RK_C;
      end
      S_RK_C: begin
        p_we = 1'b1;
        if (rka_q > r_rdata) begin
          p_waddr = root_q;
          p_wdata = ra_q;
        end else begin
          p_waddr = ra_q;
          p_wdata = root_q;
          if ((rka_q == r_rdata) && (r_rdata != RankMax)) begin
            r_we    = 1'b1;
            r_waddr = root_q;
            r_wdata = r_rdata + RankW'(1);
          end
        end
        if (comp_q != '0) begin
          comp_d = comp_q - NodeW'(1);
        end
        done_d   = 1'b1;
        merged_d = 1'b1;
        err_d    = 1'b0;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      node_count_q <= NodeCountRst;
      comp_q       <= CompRst;
      edge_q       <= '0;
      cur_q        <= '0;
      phase_q      <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      comp_q  <= comp_d;
      edge_q  <= edge_d;
      cur_q   <= cur_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    bidx_q   <= bidx_d;
    root_q   <= root_d;
    ra_q     <= ra_d;
    rka_q    <= rka_d;
    merged_q <= merged_d;
    err_q    <= err_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign merged_o     = merged_q;
  assign node_error_o = err_q;
  assign components_o = comp_q;
  assign edges_seen_o = edge_q;
  assign is_tree_o    = (CntW'(edge_q) == (n_eff - CntW'(1))) &&
                        (comp_q == NodeW'(1));

endmodule
